// File: sv/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types and constants of the multimode clock divider: mode codes,
// register indexes, count limits and the residue tables of the count unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mcd_pkg;

  localparam int unsigned NUM_DIV             = 8;
  localparam int unsigned NUM_OUTPUTS_DEFAULT = 8;
  localparam int unsigned N_MODE              = 4;
  localparam int unsigned COUNT_W             = 24;
  localparam int unsigned RES_W               = 5;
  localparam int unsigned PULSE_W             = 16;
  localparam int unsigned PADDR_W             = 4;
  localparam int unsigned PDATA_W             = 32;
  localparam int unsigned S_TDATA_W           = 8;
  localparam int unsigned M_TDATA_W           = 32;

  typedef enum logic [1:0] {
    MODE_BITS  = 2'd0,
    MODE_POW2  = 2'd1,
    MODE_DEC   = 2'd2,
    MODE_PRIME = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_COUNT_UP = 2'd0,
    REG_TRIGGER  = 2'd1,
    REG_MODE     = 2'd2,
    REG_PULSE    = 2'd3
  } reg_e;

  localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd48;

  localparam logic [COUNT_W-1:0] MODE_MAX [N_MODE] = '{
    24'd512, 24'd512, 24'd362880, 24'd9699690
  };

  // Residues are kept for divisors 3, 5, 7, 9, 11, 13, 17, 19.
  localparam logic [RES_W-1:0] RES_DIV [NUM_DIV] = '{
    5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd13, 5'd17, 5'd19
  };

  // Residues of each mode's maximum count.
  localparam logic [RES_W-1:0] MAX_RES [N_MODE][NUM_DIV] = '{
    '{5'd2, 5'd2, 5'd1, 5'd8, 5'd6, 5'd5,  5'd2,  5'd18},
    '{5'd2, 5'd2, 5'd1, 5'd8, 5'd6, 5'd5,  5'd2,  5'd18},
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd11, 5'd15, 5'd18},
    '{5'd0, 5'd0, 5'd0, 5'd3, 5'd0, 5'd0,  5'd0,  5'd0}
  };

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [NUM_DIV-1:0] res_zero;
    logic               hold;
  } cnt_state_t;

endpackage

`default_nettype wire

// File: sv/mcd_count.sv
// ----------------------------------------------------------------------------
// mcd_count
// Edge detection and the shared count, with running residues of the count
// for the odd divisors so that no division is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module mcd_count (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                clock_level_i,
  input  wire logic                reset_level_i,
  input  wire logic                count_up_i,
  input  wire mcd_pkg::mode_e      mode_i,
  output mcd_pkg::cnt_state_t      next_o
);

  logic [mcd_pkg::COUNT_W-1:0] count_q, count_d;
  logic [mcd_pkg::RES_W-1:0]   res_q [mcd_pkg::NUM_DIV];
  logic [mcd_pkg::RES_W-1:0]   res_d [mcd_pkg::NUM_DIV];
  logic                        clock_prev_q, clock_prev_d;
  logic                        reset_prev_q;
  logic                        hold_q, hold_d;

  always_comb begin
    count_d      = count_q;
    res_d        = res_q;
    clock_prev_d = clock_prev_q;
    hold_d       = hold_q;
    if (reset_level_i && !reset_prev_q) begin
      hold_d = 1'b1;
      if (count_up_i) begin
        count_d = '0;
        for (int i = 0; i < mcd_pkg::NUM_DIV; i++) res_d[i] = '0;
      end else if (mode_i == mcd_pkg::MODE_BITS) begin
        count_d = mcd_pkg::MODE_MAX[mcd_pkg::MODE_BITS];
        for (int i = 0; i < mcd_pkg::NUM_DIV; i++) begin
          res_d[i] = mcd_pkg::MAX_RES[mcd_pkg::MODE_BITS][i];
        end
      end else begin
        count_d = mcd_pkg::COUNT_W'(1);
        for (int i = 0; i < mcd_pkg::NUM_DIV; i++) res_d[i] = mcd_pkg::RES_W'(1);
      end
    end else begin
      if (clock_level_i && !clock_prev_q) begin
        hold_d = 1'b0;
        if (count_up_i) begin
          if (count_q >= mcd_pkg::MODE_MAX[mode_i] - mcd_pkg::COUNT_W'(1)) begin
            count_d = '0;
            for (int i = 0; i < mcd_pkg::NUM_DIV; i++) res_d[i] = '0;
          end else begin
            count_d = count_q + mcd_pkg::COUNT_W'(1);
            for (int i = 0; i < mcd_pkg::NUM_DIV; i++) begin
              res_d[i] = (res_q[i] == mcd_pkg::RES_DIV[i] - mcd_pkg::RES_W'(1)) ?
                         '0 : res_q[i] + mcd_pkg::RES_W'(1);
            end
          end
        end else begin
          if (count_q <= mcd_pkg::COUNT_W'(1)) begin
            count_d = mcd_pkg::MODE_MAX[mode_i];
            for (int i = 0; i < mcd_pkg::NUM_DIV; i++) begin
              res_d[i] = mcd_pkg::MAX_RES[mode_i][i];
            end
          end else begin
            count_d = count_q - mcd_pkg::COUNT_W'(1);
            for (int i = 0; i < mcd_pkg::NUM_DIV; i++) begin
              res_d[i] = (res_q[i] == '0) ?
                         mcd_pkg::RES_DIV[i] - mcd_pkg::RES_W'(1) :
                         res_q[i] - mcd_pkg::RES_W'(1);
            end
          end
        end
      end
      clock_prev_d = clock_level_i;
    end
  end

  always_comb begin
    next_o.count = count_d;
    next_o.hold  = hold_d;
    for (int i = 0; i < mcd_pkg::NUM_DIV; i++) next_o.res_zero[i] = (res_d[i] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= mcd_pkg::MODE_MAX[mcd_pkg::MODE_BITS];
      res_q        <= mcd_pkg::MAX_RES[mcd_pkg::MODE_BITS];
      clock_prev_q <= 1'b0;
      reset_prev_q <= 1'b0;
      hold_q       <= 1'b1;
    end else if (step_i) begin
      count_q      <= count_d;
      res_q        <= res_d;
      clock_prev_q <= clock_prev_d;
      reset_prev_q <= reset_level_i;
      hold_q       <= hold_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/multimode_clock_divider_top.sv
// ----------------------------------------------------------------------------
// multimode_clock_divider_top
// Clock divider with binary, power-of-two, decimal and prime divisor sets,
// gate or trigger outputs, and an APB-style register port.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tdata: clock_level, reset_level
//  m_axis    out        tdata: divider_outputs, count_value
//  apb       in/out     count_up, trigger_outputs, divider_mode, pulse_ticks
//
//  One beat per cycle unless m_axis stalls; each input beat yields one output
//  beat in the cycle after it is taken. The count, flags and pulse timers
//  update in the cycle the beat is taken. A single output register holds the
//  result; s_axis_tready stays high while that register is empty or being drained.
//  Reset: count 512, outputs held low until the first clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

module multimode_clock_divider_top #(
  parameter int unsigned NUM_OUTPUTS_USED = mcd_pkg::NUM_OUTPUTS_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // [0] clock_level, [1] reset_level, [7:2] zero
  input  wire logic [mcd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [7:0] divider_outputs, [31:8] count_value
  output      logic [mcd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mcd_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [mcd_pkg::PDATA_W-1:0]    pwdata,
  output      logic [mcd_pkg::PDATA_W-1:0]    prdata,
  output      logic                           pready
);

  logic                          count_up_q;
  logic                          trigger_q;
  mcd_pkg::mode_e                mode_q;
  logic [mcd_pkg::PULSE_W-1:0]   pulse_ticks_q;
  logic                          wr_en;
  mcd_pkg::reg_e                 reg_sel;

  logic                          accept;
  logic                          out_valid_q;
  logic [mcd_pkg::M_TDATA_W-1:0] out_data_q;

  mcd_pkg::cnt_state_t           nxt;
  logic [mcd_pkg::NUM_DIV-1:0]   flags;
  logic [NUM_OUTPUTS_USED-1:0]   flags_q;
  logic [mcd_pkg::PULSE_W-1:0]   pulse_q [NUM_OUTPUTS_USED];
  logic [mcd_pkg::PULSE_W-1:0]   pulse_d [NUM_OUTPUTS_USED];
  logic [mcd_pkg::PULSE_W-1:0]   load;
  logic [mcd_pkg::NUM_DIV-1:0]   outs;

  function automatic logic [mcd_pkg::NUM_DIV-1:0] div_flags(
    mcd_pkg::mode_e              m,
    logic [mcd_pkg::COUNT_W-1:0] cnt,
    logic [mcd_pkg::NUM_DIV-1:0] rz
  );
    logic [mcd_pkg::NUM_DIV-1:0] f;
    f = '0;
    case (m)
      mcd_pkg::MODE_BITS: f = cnt[mcd_pkg::NUM_DIV-1:0];
      mcd_pkg::MODE_POW2: begin
        for (int c = 0; c < mcd_pkg::NUM_DIV; c++) begin
          f[c] = ~|(cnt[mcd_pkg::NUM_DIV-1:0] &
                    mcd_pkg::NUM_DIV'((16'd2 << c) - 16'd1));
        end
      end
      mcd_pkg::MODE_DEC: begin
        f = {rz[3], ~|cnt[2:0], rz[2], ~cnt[0] & rz[0],
             rz[1], ~|cnt[1:0], rz[0], ~cnt[0]};
      end
      mcd_pkg::MODE_PRIME: begin
        f = {rz[7], rz[6], rz[5], rz[4], rz[2], rz[1], rz[0], ~cnt[0]};
      end
      default: f = '0;
    endcase
    return f;
  endfunction

  // Register port
  assign pready  = 1'b1;
  assign reg_sel = mcd_pkg::reg_e'(paddr[mcd_pkg::PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (reg_sel)
      mcd_pkg::REG_COUNT_UP: prdata[0] = count_up_q;
      mcd_pkg::REG_TRIGGER:  prdata[0] = trigger_q;
      mcd_pkg::REG_MODE:     prdata[1:0] = mode_q;
      mcd_pkg::REG_PULSE:    prdata[mcd_pkg::PULSE_W-1:0] = pulse_ticks_q;
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_up_q    <= 1'b0;
      trigger_q     <= 1'b0;
      mode_q        <= mcd_pkg::MODE_BITS;
      pulse_ticks_q <= mcd_pkg::PULSE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        mcd_pkg::REG_COUNT_UP: count_up_q    <= pwdata[0];
        mcd_pkg::REG_TRIGGER:  trigger_q     <= pwdata[0];
        mcd_pkg::REG_MODE:     mode_q        <= mcd_pkg::mode_e'(pwdata[1:0]);
        mcd_pkg::REG_PULSE:    pulse_ticks_q <= pwdata[mcd_pkg::PULSE_W-1:0];
        default:               count_up_q    <= count_up_q;
      endcase
    end
  end

  // Stream handshake
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  mcd_count u_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .clock_level_i (s_axis_tdata[0]),
    .reset_level_i (s_axis_tdata[1]),
    .count_up_i    (count_up_q),
    .mode_i        (mode_q),
    .next_o        (nxt)
  );

  assign flags = nxt.hold ? '0 : div_flags(mode_q, nxt.count, nxt.res_zero);
  assign load  = (pulse_ticks_q == '0) ? '0 : pulse_ticks_q - mcd_pkg::PULSE_W'(1);

  always_comb begin
    outs = '0;
    for (int c = 0; c < NUM_OUTPUTS_USED; c++) begin
      if (trigger_q && flags[c] && !flags_q[c]) begin
        pulse_d[c] = (load > pulse_q[c]) ? load : pulse_q[c];
        outs[c]    = 1'b1;
      end else begin
        pulse_d[c] = (pulse_q[c] != '0) ? pulse_q[c] - mcd_pkg::PULSE_W'(1) : pulse_q[c];
        outs[c]    = trigger_q ? (pulse_q[c] != '0) : flags[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      for (int c = 0; c < NUM_OUTPUTS_USED; c++) pulse_q[c] <= '0;
    end else if (accept) begin
      flags_q <= flags[NUM_OUTPUTS_USED-1:0];
      pulse_q <= pulse_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {nxt.count, outs};
    end
  end

endmodule

`default_nettype wire
